>>> design/siq_pkg.sv
// ----------------------------------------------------------------------------
// siq_pkg
// Shared types and codes for the sorted insert queue.
// ----------------------------------------------------------------------------
package siq_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] ACT_INSERT     = 2'd0;
  localparam logic [1:0] ACT_REMOVE_MIN = 2'd1;
  localparam logic [1:0] ACT_REMOVE_MAX = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } siq_state_t;

  typedef struct packed {
    logic                     ins;
    logic                     shl;
    logic signed [DATA_W-1:0] val;
  } siq_cmd_t;

endpackage

>>> design/siq_cell.sv
// ----------------------------------------------------------------------------
// siq_cell
// One entry of the sorted row. It compares its entry with the value being
// inserted and takes its own, the new, or a neighbor's entry.
// ----------------------------------------------------------------------------
module siq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                              clk,
  input  siq_pkg::siq_cmd_t                 cmd,
  input  logic [CW-1:0]                     count,
  input  logic signed [siq_pkg::DATA_W-1:0] left_entry,
  input  logic                              left_lt,
  input  logic signed [siq_pkg::DATA_W-1:0] right_entry,
  output logic signed [siq_pkg::DATA_W-1:0] entry,
  output logic                              lt,
  output logic signed [siq_pkg::DATA_W-1:0] tap
);
  import siq_pkg::*;

  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] LAST_C = CW'(IDX + 1);

  logic                     occ;
  logic signed [DATA_W-1:0] ins_val;

  assign occ     = (count > IDX_C);
  assign lt      = occ && (entry < $signed(cmd.val));
  assign ins_val = lt ? entry : (left_lt ? cmd.val : left_entry);
  assign tap     = (count == LAST_C) ? entry : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      entry <= ins_val;
    end else if (cmd.shl) begin
      entry <= right_entry;
    end
  end

endmodule

>>> design/siq_max_tree.sv
// ----------------------------------------------------------------------------
// siq_max_tree
// Registered OR tree that gathers the single nonzero tap of the row; each
// level of the tree is registered.
// ----------------------------------------------------------------------------
module siq_max_tree #(
  parameter int N  = 16,
  parameter int LV = 4
) (
  input  logic                       clk,
  input  logic [N-1:0][siq_pkg::DATA_W-1:0] taps,
  output logic [siq_pkg::DATA_W-1:0] top
);
  import siq_pkg::*;

  localparam int PAD = 1 << LV;

  logic [DATA_W-1:0] node [LV+1][PAD];

  for (genvar j = 0; j < PAD; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign node[0][j] = taps[j];
    end else begin : g_pad
      assign node[0][j] = '0;
    end
  end

  for (genvar k = 1; k <= LV; k++) begin : g_lvl
    for (genvar j = 0; j < PAD; j++) begin : g_node
      if (j < (PAD >> k)) begin : g_or
        always_ff @(posedge clk) begin
          node[k][j] <= node[k-1][2*j] | node[k-1][2*j+1];
        end
      end else begin : g_zero
        assign node[k][j] = '0;
      end
    end
  end

  assign top = node[LV][0];

endmodule

>>> design/sorted_insert_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_queue
// Insert and remove-smallest push their result into the output queue in the
// cycle they are taken; remove-largest waits in ST_WAIT for the registered OR
// tree that reads the last entry and pushes its result from there. A new
// transaction is taken every cycle while the output queue has room, but not
// during ST_WAIT. A synchronous reset empties the store and the output queue.
// ----------------------------------------------------------------------------
module sorted_insert_queue #(
  parameter int DEPTH = siq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        action,
  input  logic signed [siq_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [siq_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                        status
);
  import siq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int LV   = $clog2(DEPTH);
  localparam int WCW  = (LV > 1) ? $clog2(LV) : 1;
  localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);
  localparam logic [WCW-1:0] WAIT_C  = WCW'(LV - 1);

  siq_state_t state, state_next;
  logic [CW-1:0]  count, count_next;
  logic [WCW-1:0] wait_cnt, wait_cnt_next;

  siq_cmd_t cmd;
  logic signed [DATA_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]         lts;
  logic [DEPTH-1:0][DATA_W-1:0] taps;
  logic [DATA_W-1:0]        max_val;

  logic              accept, push, pop;
  logic [DATA_W-1:0] push_val;
  logic [1:0]        push_st;

  logic [DATA_W-1:0] q_val [2];
  logic [1:0]        q_st [2];
  logic              rd_ptr, wr_ptr;
  logic [1:0]        fill;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] l_entry, r_entry;
    logic                     l_lt;
    logic signed [DATA_W-1:0] t;
    if (i == 0) begin : g_first
      assign l_entry = '0;
      assign l_lt    = 1'b1;
    end else begin : g_mid
      assign l_entry = entries[i-1];
      assign l_lt    = lts[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_entry = entries[i];
    end else begin : g_inner
      assign r_entry = entries[i+1];
    end
    siq_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .left_entry (l_entry),
      .left_lt    (l_lt),
      .right_entry(r_entry),
      .entry      (entries[i]),
      .lt         (lts[i]),
      .tap        (t)
    );
    assign taps[i] = t;
  end

  siq_max_tree #(.N(DEPTH), .LV(LV)) u_tree (
    .clk (clk),
    .taps(taps),
    .top (max_val)
  );

  assign in_stall = (state != ST_IDLE) || (fill == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign out_valid = (fill != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign result_value = q_val[rd_ptr];
  assign status       = q_st[rd_ptr];

  always_comb begin
    state_next    = state;
    count_next    = count;
    wait_cnt_next = wait_cnt;
    cmd.ins       = 1'b0;
    cmd.shl       = 1'b0;
    cmd.val       = value;
    push          = 1'b0;
    push_val      = '0;
    push_st       = STAT_OK;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          push = 1'b1;
          case (action)
            ACT_INSERT: begin
              if (count == DEPTH_C) begin
                push_st = STAT_FULL;
              end else begin
                cmd.ins    = 1'b1;
                push_val   = value;
                count_next = count + 1'b1;
              end
            end
            ACT_REMOVE_MIN: begin
              if (count == '0) begin
                push_st = STAT_EMPTY;
              end else begin
                cmd.shl    = 1'b1;
                push_val   = entries[0];
                count_next = count - 1'b1;
              end
            end
            ACT_REMOVE_MAX: begin
              if (count == '0) begin
                push_st = STAT_EMPTY;
              end else begin
                push          = 1'b0;
                wait_cnt_next = '0;
                state_next    = ST_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WAIT: begin
        if (wait_cnt == WAIT_C) begin
          push       = 1'b1;
          push_val   = max_val;
          count_next = count - 1'b1;
          state_next = ST_IDLE;
        end else begin
          wait_cnt_next = wait_cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      wait_cnt <= '0;
      rd_ptr   <= 1'b0;
      wr_ptr   <= 1'b0;
      fill     <= 2'd0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      wait_cnt <= wait_cnt_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_val[wr_ptr] <= push_val;
      q_st[wr_ptr]  <= push_st;
    end
  end

endmodule
